/* rtl/log_record_block_framer_unit_defines.svh */
// assertion macros shared by the checker
`ifndef LOG_RECORD_BLOCK_FRAMER_UNIT_DEFINES_SVH
`define LOG_RECORD_BLOCK_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define LRBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication
`define LRBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

/* rtl/lrbf_pkg.sv */
`timescale 1ns / 1ps
package lrbf_pkg;

    localparam int HDR_BYTES = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_DELTA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_TYPE     = 2'd2;

    localparam logic [7:0] TYPE_FULL   = 8'd1;
    localparam logic [7:0] TYPE_FIRST  = 8'd2;
    localparam logic [7:0] TYPE_MIDDLE = 8'd3;
    localparam logic [7:0] TYPE_LAST   = 8'd4;

    localparam logic [31:0] MASK_DELTA_RST = 32'hA282_EAD8;
    localparam logic [7:0]  END_TYPE_RST   = 8'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       record_end;
    } t_in;

    typedef struct packed {
        logic [31:0] block_number;
        logic [14:0] byte_offset;
        logic [7:0]  byte_value;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [31:0] crc_m;
        logic [15:0] len;
        logic [7:0]  typ;
    } t_hdr;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    function automatic logic [31:0] mask_crc(input logic [31:0] crc, input logic [31:0] delta);
        logic [31:0] c;
        c = ~crc;
        return {c[14:0], c[31:15]} + delta;
    endfunction

    function automatic logic [7:0] hdr_byte(input t_hdr h, input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = h.crc_m[7:0];
            3'd1: v = h.crc_m[15:8];
            3'd2: v = h.crc_m[23:16];
            3'd3: v = h.crc_m[31:24];
            3'd4: v = h.len[7:0];
            3'd5: v = h.len[15:8];
            3'd6: v = h.typ;
            default: v = '0;
        endcase
        return v;
    endfunction

    localparam logic [31:0] CRC_START_FULL   = crc_byte(32'hFFFF_FFFF, TYPE_FULL);
    localparam logic [31:0] CRC_START_FIRST  = crc_byte(32'hFFFF_FFFF, TYPE_FIRST);
    localparam logic [31:0] CRC_START_MIDDLE = crc_byte(32'hFFFF_FFFF, TYPE_MIDDLE);
    localparam logic [31:0] CRC_START_LAST   = crc_byte(32'hFFFF_FFFF, TYPE_LAST);

endpackage

/* rtl/log_record_block_framer_unit.sv */
`timescale 1ns / 1ps
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_ready     lrbf_pkg::t_in  i_in_data
// out       out  o_out_valid / i_out_ready   lrbf_pkg::t_out o_out_data
// cfg       in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// one item a cycle while each item gives one write (payload inside a fragment) and i_out_ready
// a multi-write item holds the input until its last write; one write goes per ready cycle
// one skid register on the input lets an item in while a write waits at the output
// a start_offset write reduces the offset modulo block size (quot, rem, fix), input held off
// reset is synchronous, active low, and loads the register defaults
module log_record_block_framer_unit #(
    parameter int BLOCK_BYTES = 32768
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lrbf_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lrbf_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [lrbf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);

    localparam int WO_W  = $clog2(BLOCK_BYTES + 1);
    localparam int FS_W  = $clog2(BLOCK_BYTES);
    localparam int MOD_M = 32768 / BLOCK_BYTES;
    localparam int QW    = $clog2(MOD_M + 2);
    localparam int FW    = (WO_W > 15) ? WO_W : 15;
    localparam logic [WO_W-1:0] BLK_END = WO_W'(BLOCK_BYTES);
    localparam logic [WO_W-1:0] HDR_W   = WO_W'(lrbf_pkg::HDR_BYTES);
    localparam logic [FW-1:0]   BLK_F   = FW'(BLOCK_BYTES);

    typedef enum logic [1:0] {MOD_IDLE, MOD_QUOT, MOD_REM, MOD_FIX} t_mod_state;
    typedef enum logic [1:0] {SEG_PAD, SEG_H1, SEG_PL, SEG_H2} t_seg;

    typedef struct packed {
        logic [3:0]      en;
        logic [2:0]      pad_n;
        logic [WO_W-1:0] pad_off;
        logic [31:0]     b0;
        logic [31:0]     b1;
        logic            h1_late;
        logic [WO_W-1:0] h1_off;
        lrbf_pkg::t_hdr  h1;
        logic [WO_W-1:0] pl_off;
        logic [7:0]      pl_byte;
        logic [FS_W-1:0] h2_off;
        lrbf_pkg::t_hdr  h2;
    } t_run;

    // config
    logic [31:0] r_mask_delta;
    logic [7:0]  r_end_code;

    // offset reduction
    t_mod_state  r_mod_state;
    logic [14:0] r_mod_v;
    logic [QW-1:0] r_mod_q;
    logic [14:0] r_mod_r;
    logic [QW-1:0] n_mod_q;
    logic [14:0] n_mod_r;
    logic [FW-1:0] mod_rr;
    logic [FW-1:0] mod_fix;

    // framing state
    logic [WO_W-1:0] r_wo;
    logic [FS_W-1:0] r_fs;
    logic [15:0]     r_len;
    logic [31:0]     r_crc_e;
    logic [31:0]     r_crc_c;
    logic            r_rb;
    logic            r_open;
    logic [31:0]     r_blk;

    // skid and run registers
    logic            r_in_valid;
    lrbf_pkg::t_in   r_in;
    logic            r_run_valid;
    t_run            r_run;
    t_seg            r_seg;
    logic [2:0]      r_sub;

    logic [WO_W-1:0] left;
    logic [WO_W-1:0] wo_base;
    logic [WO_W-1:0] pl_off;
    logic [WO_W-1:0] wo_after;
    logic            is_pay;
    logic            is_mark;
    logic            opening;
    logic            need_pad;
    logic            at_hdr;
    logic            pad;
    logic            lone;
    logic            rb1;
    logic            close_end;
    logic            close_cont;
    logic [31:0]     blk_next;
    logic [31:0]     crc_e_in;
    logic [31:0]     crc_c_in;
    logic [31:0]     crc_e_new;
    logic [31:0]     crc_c_new;
    logic [FS_W-1:0] fs_new;
    logic [15:0]     len_new;
    logic [7:0]      h1_type;
    logic [7:0]      h2_type;
    t_run            n_run;
    logic            n_run_valid;
    t_seg            n_first;

    logic            seg_end;
    logic [3:0]      above;
    logic [3:0]      after;
    logic            out_last;
    t_seg            seg_next;
    logic [WO_W-1:0] out_off;
    logic            out_fire;
    logic            run_free;
    logic            move;

    // offset reduction datapath
    always_comb begin
        n_mod_q = QW'((32'(r_mod_v) * MOD_M) >> 15);
        n_mod_r = r_mod_v - 15'(32'(r_mod_q) * BLOCK_BYTES);
        mod_rr  = FW'(r_mod_r);
        mod_fix = (mod_rr >= BLK_F) ? mod_rr - BLK_F : mod_rr;
    end

    // item processing
    always_comb begin
        left     = BLK_END - r_wo;
        is_pay   = r_in.kind == lrbf_pkg::KIND_PAYLOAD;
        is_mark  = (r_in.kind == lrbf_pkg::KIND_EMPTY || r_in.kind == lrbf_pkg::KIND_END)
                   && !r_open && !r_rb;
        opening  = is_pay && !r_open;
        need_pad = left < HDR_W;
        at_hdr   = left == HDR_W;
        pad      = (opening || is_mark) && need_pad;
        lone     = opening && at_hdr;
        wo_base  = (pad || lone) ? '0 : r_wo;
        rb1      = r_rb || lone;
        blk_next = r_blk + 32'(pad || lone);
        fs_new   = opening ? FS_W'(wo_base) : r_fs;
        pl_off   = opening ? wo_base + HDR_W : r_wo;
        wo_after = pl_off + WO_W'(1);

        crc_e_in  = r_open ? r_crc_e
                  : (rb1 ? lrbf_pkg::CRC_START_LAST : lrbf_pkg::CRC_START_FULL);
        crc_c_in  = r_open ? r_crc_c
                  : (rb1 ? lrbf_pkg::CRC_START_MIDDLE : lrbf_pkg::CRC_START_FIRST);
        crc_e_new = lrbf_pkg::crc_byte(crc_e_in, r_in.data_byte);
        crc_c_new = lrbf_pkg::crc_byte(crc_c_in, r_in.data_byte);
        len_new   = r_open ? r_len + 16'd1 : 16'd1;

        close_end  = is_pay && r_in.record_end;
        close_cont = is_pay && !r_in.record_end && (wo_after >= BLK_END);

        if (is_mark) begin
            h1_type = (r_in.kind == lrbf_pkg::KIND_EMPTY) ? lrbf_pkg::TYPE_FULL : r_end_code;
        end else begin
            h1_type = r_rb ? lrbf_pkg::TYPE_MIDDLE : lrbf_pkg::TYPE_FIRST;
        end
        if (close_end) begin
            h2_type = rb1 ? lrbf_pkg::TYPE_LAST : lrbf_pkg::TYPE_FULL;
        end else begin
            h2_type = rb1 ? lrbf_pkg::TYPE_MIDDLE : lrbf_pkg::TYPE_FIRST;
        end

        n_run.en[SEG_PAD] = pad && (left != '0);
        n_run.en[SEG_H1]  = is_mark || lone;
        n_run.en[SEG_PL]  = is_pay;
        n_run.en[SEG_H2]  = close_end || close_cont;
        n_run.pad_n       = 3'(left);
        n_run.pad_off     = r_wo;
        n_run.b0          = r_blk;
        n_run.b1          = blk_next;
        n_run.h1_late     = is_mark;
        n_run.h1_off      = is_mark ? wo_base : r_wo;
        n_run.h1.crc_m    = lrbf_pkg::mask_crc(lrbf_pkg::crc_byte(32'hFFFF_FFFF, h1_type),
                                               r_mask_delta);
        n_run.h1.len      = 16'd0;
        n_run.h1.typ      = h1_type;
        n_run.pl_off      = pl_off;
        n_run.pl_byte     = r_in.data_byte;
        n_run.h2_off      = fs_new;
        n_run.h2.crc_m    = lrbf_pkg::mask_crc(close_end ? crc_e_new : crc_c_new, r_mask_delta);
        n_run.h2.len      = len_new;
        n_run.h2.typ      = h2_type;
        n_run_valid       = |n_run.en;

        priority if (n_run.en[SEG_PAD]) begin
            n_first = SEG_PAD;
        end else if (n_run.en[SEG_H1]) begin
            n_first = SEG_H1;
        end else if (n_run.en[SEG_PL]) begin
            n_first = SEG_PL;
        end else begin
            n_first = SEG_H2;
        end
    end

    // write sequencer
    always_comb begin
        unique case (r_seg)
            SEG_PAD: begin
                seg_end = r_sub == (r_run.pad_n - 3'd1);
                above   = 4'b1110;
            end
            SEG_H1: begin
                seg_end = r_sub == lrbf_pkg::HDR_LAST;
                above   = 4'b1100;
            end
            SEG_PL: begin
                seg_end = 1'b1;
                above   = 4'b1000;
            end
            SEG_H2: begin
                seg_end = r_sub == lrbf_pkg::HDR_LAST;
                above   = 4'b0000;
            end
            default: begin
                seg_end = 1'b1;
                above   = 4'b0000;
            end
        endcase
        after    = r_run.en & above;
        out_last = seg_end && (after == 4'b0000);

        priority if (after[SEG_H1]) begin
            seg_next = SEG_H1;
        end else if (after[SEG_PL]) begin
            seg_next = SEG_PL;
        end else begin
            seg_next = SEG_H2;
        end

        unique case (r_seg)
            SEG_PAD: begin
                out_off                 = r_run.pad_off + WO_W'(r_sub);
                o_out_data.block_number = r_run.b0;
                o_out_data.byte_value   = 8'd0;
            end
            SEG_H1: begin
                out_off                 = r_run.h1_off + WO_W'(r_sub);
                o_out_data.block_number = r_run.h1_late ? r_run.b1 : r_run.b0;
                o_out_data.byte_value   = lrbf_pkg::hdr_byte(r_run.h1, r_sub);
            end
            SEG_PL: begin
                out_off                 = r_run.pl_off;
                o_out_data.block_number = r_run.b1;
                o_out_data.byte_value   = r_run.pl_byte;
            end
            SEG_H2: begin
                out_off                 = WO_W'(r_run.h2_off) + WO_W'(r_sub);
                o_out_data.block_number = r_run.b1;
                o_out_data.byte_value   = lrbf_pkg::hdr_byte(r_run.h2, r_sub);
            end
            default: begin
                out_off                 = '0;
                o_out_data.block_number = '0;
                o_out_data.byte_value   = '0;
            end
        endcase
        o_out_data.byte_offset = 15'(out_off);
        o_out_data.last_of_run = out_last;
    end

    assign o_out_valid = r_run_valid;
    assign out_fire    = r_run_valid && i_out_ready;
    assign run_free    = !r_run_valid || (out_fire && out_last);
    assign move        = r_in_valid && run_free && (r_mod_state == MOD_IDLE);
    assign o_in_ready  = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_delta <= lrbf_pkg::MASK_DELTA_RST;
            r_end_code   <= lrbf_pkg::END_TYPE_RST;
            r_mod_state  <= MOD_IDLE;
            r_wo         <= '0;
            r_fs         <= '0;
            r_len        <= '0;
            r_rb         <= 1'b0;
            r_open       <= 1'b0;
            r_blk        <= '0;
            r_in_valid   <= 1'b0;
            r_run_valid  <= 1'b0;
            r_seg        <= SEG_PAD;
            r_sub        <= '0;
        end else begin
            // input skid
            if (i_in_valid && o_in_ready) begin
                r_in       <= i_in_data;
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            // run register and sequencer
            if (move) begin
                r_run       <= n_run;
                r_run_valid <= n_run_valid;
                r_seg       <= n_first;
                r_sub       <= '0;
            end else if (out_fire) begin
                if (out_last) begin
                    r_run_valid <= 1'b0;
                end else if (seg_end) begin
                    r_seg <= seg_next;
                    r_sub <= '0;
                end else begin
                    r_sub <= r_sub + 3'd1;
                end
            end

            // framing state
            if (move && is_pay) begin
                r_wo    <= wo_after;
                r_fs    <= fs_new;
                r_len   <= len_new;
                r_crc_e <= crc_e_new;
                r_crc_c <= crc_c_new;
                r_blk   <= blk_next;
                r_open  <= !(close_end || close_cont);
                r_rb    <= close_end ? 1'b0 : (close_cont ? 1'b1 : rb1);
            end else if (move && is_mark) begin
                r_wo  <= wo_base + HDR_W;
                r_blk <= blk_next;
            end

            // offset reduction, restarted by every start_offset write
            if (i_cfg_we && i_cfg_idx == lrbf_pkg::REG_START_OFFSET) begin
                r_mod_state <= MOD_QUOT;
            end else begin
                unique case (r_mod_state)
                    MOD_IDLE: ;
                    MOD_QUOT: begin
                        r_mod_q     <= n_mod_q;
                        r_mod_state <= MOD_REM;
                    end
                    MOD_REM: begin
                        r_mod_r     <= n_mod_r;
                        r_mod_state <= MOD_FIX;
                    end
                    MOD_FIX: begin
                        r_wo        <= WO_W'(mod_fix);
                        r_mod_state <= MOD_IDLE;
                    end
                    default: r_mod_state <= MOD_IDLE;
                endcase
            end

            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lrbf_pkg::REG_MASK_DELTA: r_mask_delta <= i_cfg_data;
                    lrbf_pkg::REG_START_OFFSET: begin
                        r_mod_v <= i_cfg_data[14:0];
                        r_open  <= 1'b0;
                        r_rb    <= 1'b0;
                    end
                    lrbf_pkg::REG_END_TYPE: r_end_code <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/lrbf_checker.sv */
`timescale 1ns / 1ps
`include "log_record_block_framer_unit_defines.svh"
module lrbf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lrbf_pkg::t_out o_out_data,
    input logic           i_cfg_we
);

    // stalled write holds
    `LRBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // writes of one item leave with no gap
    `LRBF_ASSERT_NEXT(a_run_gapless, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_data.last_of_run, o_out_valid)

    // block number steps by at most one between writes
    `LRBF_ASSERT_NEXT(a_block_step, i_clk, i_rst_n, o_out_valid && i_out_ready, !o_out_valid || o_out_data.block_number == $past(o_out_data.block_number) || o_out_data.block_number == $past(o_out_data.block_number) + 32'd1)

    // empty output and no recent register write means input open
    `LRBF_ASSERT_SAME(a_in_open, i_clk, i_rst_n, !o_out_valid && !$past(i_cfg_we) && !$past(i_cfg_we, 2) && !$past(i_cfg_we, 3), o_in_ready)

endmodule

bind log_record_block_framer_unit lrbf_checker u_lrbf_checker (.*);
